>>> design/assert_macros.svh
// Assertion macros used by the drive motor speed controller result buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> design/dmsc_pkg.sv
// Package of types, constants and helpers for the drive motor speed controller.
package dmsc_pkg;

   localparam int REVERSE_ARM_LIMIT = 50;
   localparam int ARM_W = $clog2(REVERSE_ARM_LIMIT + 1);
   localparam logic [ARM_W-1:0] ARM_LIMIT = ARM_W'(REVERSE_ARM_LIMIT);

   localparam logic [13:0] DUTY_MAX = 14'd10000;

   // Input item codes
   localparam logic CMD_PULSE = 1'b0;
   localparam logic CMD_DRIVE = 1'b1;
   localparam logic [7:0] SPEED_STOP = 8'd0;
   localparam logic [7:0] SPEED_SLOW = 8'd5;

   // Speed error thresholds in milli-mph
   localparam logic signed [24:0] ERR_RAISE = 25'sd500;
   localparam logic signed [24:0] ERR_BRAKE = -25'sd150;
   localparam logic signed [24:0] ERR_EASE = -25'sd100;
   // Magnitude steps where the error/20 quotient moves from 5 to 6 and 6 to 7
   localparam logic [7:0] EASE_STEP6 = 8'd120;
   localparam logic [7:0] EASE_STEP7 = 8'd140;

   // ceil(2^18 / 5): exact reciprocal for 13-bit dividends
   localparam logic [15:0] RECIP5 = 16'd52429;
   localparam int RECIP5_SHIFT = 18;

   typedef enum logic [2:0] {
      CSR_PULSE_SPEED_GAIN,
      CSR_TARGET_SPEED,
      CSR_START_DUTY,
      CSR_STOP_DUTY,
      CSR_BRAKE_DUTY,
      CSR_MIN_RUN_DUTY,
      CSR_REVERSE_KICK_DUTY,
      CSR_REVERSE_HOLD_DUTY
   } csr_index_type;

   typedef struct packed {
      logic [15:0] pulse_speed_gain;
      logic [15:0] target_speed;
      logic [13:0] start_duty;
      logic [13:0] stop_duty;
      logic [13:0] brake_duty;
      logic [13:0] min_run_duty;
      logic [13:0] reverse_kick_duty;
      logic [13:0] reverse_hold_duty;
   } cfg_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] speed_request;
      logic       forward_flag;
      logic       reverse_flag;
   } item_type;

   // Results caused by one item: count and up to two duties in order
   typedef struct packed {
      logic [1:0]  n;
      logic [13:0] duty0;
      logic [13:0] duty1;
   } res_type;

   function automatic logic [13:0] sat_duty(input logic [14:0] v);
      return (v > {1'b0, DUTY_MAX}) ? DUTY_MAX : v[13:0];
   endfunction

endpackage

>>> design/dmsc_csr.sv
// Configuration register bank with reset values and a plain write port.
module dmsc_csr (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write_enable,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_wdata,
   output dmsc_pkg::cfg_type   cfg,
   output logic [15:0]         gain_next
);

   dmsc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (dmsc_pkg::csr_index_type'(csr_index))
            dmsc_pkg::CSR_PULSE_SPEED_GAIN:  cfg_in.pulse_speed_gain  = csr_wdata;
            dmsc_pkg::CSR_TARGET_SPEED:      cfg_in.target_speed      = csr_wdata;
            dmsc_pkg::CSR_START_DUTY:        cfg_in.start_duty        = csr_wdata[13:0];
            dmsc_pkg::CSR_STOP_DUTY:         cfg_in.stop_duty         = csr_wdata[13:0];
            dmsc_pkg::CSR_BRAKE_DUTY:        cfg_in.brake_duty        = csr_wdata[13:0];
            dmsc_pkg::CSR_MIN_RUN_DUTY:      cfg_in.min_run_duty      = csr_wdata[13:0];
            dmsc_pkg::CSR_REVERSE_KICK_DUTY: cfg_in.reverse_kick_duty = csr_wdata[13:0];
            dmsc_pkg::CSR_REVERSE_HOLD_DUTY: cfg_in.reverse_hold_duty = csr_wdata[13:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pulse_speed_gain  <= 16'd15734;
         cfg_ff.target_speed      <= 16'd1700;
         cfg_ff.start_duty        <= 14'd1685;
         cfg_ff.stop_duty         <= 14'd1560;
         cfg_ff.brake_duty        <= 14'd1010;
         cfg_ff.min_run_duty      <= 14'd1540;
         cfg_ff.reverse_kick_duty <= 14'd1600;
         cfg_ff.reverse_hold_duty <= 14'd1530;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg       = cfg_ff;
   assign gain_next = reset ? 16'd15734 : cfg_in.pulse_speed_gain;

endmodule

>>> design/dmsc_ctrl.sv
// Controller state and the single-pass duty computation for one item.
module dmsc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  dmsc_pkg::cfg_type   cfg,
   input  logic [15:0]         gain_next,
   input  dmsc_pkg::item_type  item,
   input  logic                advance,
   output dmsc_pkg::res_type   res
);

   logic [7:0]                 pulse_count_ff, pulse_count_in;
   logic [13:0]                base_duty_ff, base_duty_in;
   logic                       moving_ff, moving_in;
   logic [dmsc_pkg::ARM_W-1:0] arm_ff, arm_in, arm_step;
   logic [23:0]                speed_ff;

   logic signed [24:0] err;
   logic signed [24:0] err_neg;
   logic [13:0]        base_eff;
   logic [28:0]        recip_prod;
   logic [10:0]        raise_q;
   logic [7:0]         ease_mag;
   logic [2:0]         ease_k;
   logic [14:0]        ease_floor;
   logic [14:0]        ease_duty;
   logic               fwd_emit;
   logic [13:0]        fwd_duty;

   // Forward speed correction from the held speed product
   always_comb begin
      base_eff   = moving_ff ? base_duty_ff : cfg.start_duty;
      err        = $signed({9'd0, cfg.target_speed}) - $signed({1'b0, speed_ff});
      err_neg    = -err;
      recip_prod = {16'd0, err[15:3]} * {13'd0, dmsc_pkg::RECIP5};
      raise_q    = recip_prod[dmsc_pkg::RECIP5_SHIFT +: 11];
      ease_mag   = err_neg[7:0];
      if (ease_mag >= dmsc_pkg::EASE_STEP7) begin
         ease_k = 3'd7;
      end else if (ease_mag >= dmsc_pkg::EASE_STEP6) begin
         ease_k = 3'd6;
      end else begin
         ease_k = 3'd5;
      end
      ease_floor = {1'b0, cfg.min_run_duty} + {12'd0, ease_k};
      ease_duty  = ({1'b0, base_eff} > ease_floor) ? ({1'b0, base_eff} - {12'd0, ease_k})
                                                   : {1'b0, cfg.min_run_duty};
      fwd_emit = 1'b1;
      if (err > dmsc_pkg::ERR_RAISE) begin
         fwd_duty = dmsc_pkg::sat_duty({1'b0, base_eff} + {4'd0, raise_q});
      end else if (err < dmsc_pkg::ERR_BRAKE) begin
         fwd_duty = dmsc_pkg::sat_duty({1'b0, cfg.brake_duty});
      end else if (err < dmsc_pkg::ERR_EASE) begin
         fwd_duty = dmsc_pkg::sat_duty(ease_duty);
      end else begin
         fwd_duty = '0;
         fwd_emit = 1'b0;
      end
   end

   // Results of the held item and next state when it advances
   always_comb begin
      pulse_count_in = pulse_count_ff;
      base_duty_in   = base_duty_ff;
      moving_in      = moving_ff;
      arm_in         = arm_ff;
      arm_step       = (arm_ff < dmsc_pkg::ARM_LIMIT) ? arm_ff + 1'b1 : arm_ff;
      res            = '0;
      if (item.cmd == dmsc_pkg::CMD_PULSE) begin
         if (advance && (pulse_count_ff != 8'hFF)) pulse_count_in = pulse_count_ff + 8'd1;
      end else begin
         if (advance && !item.reverse_flag) arm_in = '0;
         if (item.speed_request == dmsc_pkg::SPEED_STOP) begin
            res.n     = 2'd1;
            res.duty0 = dmsc_pkg::sat_duty({1'b0, cfg.stop_duty});
            if (advance) begin
               moving_in    = 1'b0;
               base_duty_in = cfg.stop_duty;
            end
         end else if (item.speed_request == dmsc_pkg::SPEED_SLOW && item.forward_flag) begin
            if (!moving_ff) begin
               res.duty0 = dmsc_pkg::sat_duty({1'b0, cfg.start_duty});
               res.duty1 = fwd_duty;
               res.n     = fwd_emit ? 2'd2 : 2'd1;
            end else begin
               res.duty0 = fwd_duty;
               res.n     = fwd_emit ? 2'd1 : 2'd0;
            end
            if (advance) begin
               moving_in      = 1'b1;
               base_duty_in   = base_eff;
               pulse_count_in = '0;
            end
         end else if (item.speed_request == dmsc_pkg::SPEED_SLOW && item.reverse_flag) begin
            if (arm_step < dmsc_pkg::ARM_LIMIT) begin
               res.n     = 2'd2;
               res.duty0 = dmsc_pkg::sat_duty({1'b0, cfg.reverse_kick_duty});
               res.duty1 = dmsc_pkg::sat_duty({1'b0, cfg.reverse_hold_duty});
            end else begin
               res.n     = 2'd1;
               res.duty0 = dmsc_pkg::sat_duty({1'b0, cfg.reverse_hold_duty});
            end
            if (advance) arm_in = arm_step;
         end else begin
            res.n     = 2'd1;
            res.duty0 = dmsc_pkg::sat_duty({1'b0, cfg.stop_duty});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_count_ff <= '0;
         base_duty_ff   <= 14'd1700;
         moving_ff      <= 1'b0;
         arm_ff         <= '0;
         speed_ff       <= '0;
      end else begin
         pulse_count_ff <= pulse_count_in;
         base_duty_ff   <= base_duty_in;
         moving_ff      <= moving_in;
         arm_ff         <= arm_in;
         // keep the speed product in step with the count and the gain
         speed_ff       <= {8'd0, gain_next} * {16'd0, pulse_count_in};
      end
   end

endmodule

>>> design/dmsc_rsp_buf.sv
// Two-entry result buffer that presents results in order on the response channel.
`include "assert_macros.svh"

module dmsc_rsp_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  dmsc_pkg::res_type  res,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [13:0]        rsp_duty,
   output logic               rsp_last,
   output logic               free
);

   logic [1:0]  nres_ff, nres_in;
   logic [13:0] duty0_ff, duty0_in;
   logic        last0_ff, last0_in;
   logic [13:0] duty1_ff, duty1_in;
   logic        pop;

   assign rsp_valid = (nres_ff != 2'd0);
   assign rsp_duty  = duty0_ff;
   assign rsp_last  = last0_ff;
   assign pop       = rsp_valid && rsp_ready;
   assign free      = (nres_ff == 2'd0) || ((nres_ff == 2'd1) && rsp_ready);

   always_comb begin
      nres_in  = nres_ff;
      duty0_in = duty0_ff;
      last0_in = last0_ff;
      duty1_in = duty1_ff;
      if (load) begin
         nres_in  = res.n;
         duty0_in = res.duty0;
         last0_in = (res.n == 2'd1);
         duty1_in = res.duty1;
      end else if (pop) begin
         // advance the second result to the head
         nres_in  = nres_ff - 2'd1;
         duty0_in = duty1_ff;
         last0_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nres_ff <= '0;
      end else begin
         nres_ff <= nres_in;
      end
      duty0_ff <= duty0_in;
      last0_ff <= last0_in;
      duty1_ff <= duty1_in;
   end

   `ASSERT_IMPLY(a_load_needs_room, load, free, "result load into a busy buffer")
   `ASSERT_IMPLY(a_pair_head_not_last, nres_ff == 2'd2, !last0_ff, "head of a pair marked last")
   `ASSERT_IMPLY(a_single_is_last, nres_ff == 2'd1, last0_ff, "lone result not marked last")
   `ASSERT_IMPLY(a_duty_in_range, rsp_valid, rsp_duty <= dmsc_pkg::DUTY_MAX, "duty above 10000")

endmodule

>>> design/drive_motor_speed_controller_core.sv
// Top level of the drive motor speed controller: input register, control and result buffer.
// A request is held in the input register and its results in the result buffer.
// One request is taken per cycle while the result buffer has room; a request that yields two
// duties holds the next request that has a result while the result buffer drains the pair.
// Pulse requests, and forward requests without a correction while moving, yield no result.
// Reset (synchronous, active high): register defaults, counts and moving flag clear, base 1700.
module drive_motor_speed_controller_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [7:0]  req_speed_request,
   input  logic        req_forward_flag,
   input  logic        req_reverse_flag,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [13:0] rsp_duty,
   output logic        rsp_last,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   dmsc_pkg::cfg_type  cfg;
   logic [15:0]        gain_next;
   dmsc_pkg::item_type item_ff, item_in;
   logic               in_valid_ff, in_valid_in;
   dmsc_pkg::res_type  res;
   logic               advance;
   logic               load;
   logic               free;
   logic               req_transfer;

   // Hand the held request on when its results fit into the buffer; requests without a
   // result never wait for the response side.
   assign advance      = in_valid_ff && ((res.n == 2'd0) || free);
   assign load         = advance && (res.n != 2'd0);
   assign req_ready    = !in_valid_ff || advance;
   assign req_transfer = req_valid && req_ready;

   always_comb begin
      item_in     = item_ff;
      in_valid_in = in_valid_ff;
      if (req_transfer) begin
         item_in.cmd           = req_cmd;
         item_in.speed_request = req_speed_request;
         item_in.forward_flag  = req_forward_flag;
         item_in.reverse_flag  = req_reverse_flag;
         in_valid_in           = 1'b1;
      end else if (advance) begin
         // drop the request once processed
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      item_ff <= item_in;
   end

   dmsc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg),
      .gain_next        (gain_next)
   );

   dmsc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .gain_next (gain_next),
      .item      (item_ff),
      .advance   (advance),
      .res       (res)
   );

   dmsc_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .res       (res),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_duty  (rsp_duty),
      .rsp_last  (rsp_last),
      .free      (free)
   );

endmodule
